>>> hw/rtl/rptb_pkg.sv
// Package for the randomized Prim tree builder: sizes, codes, beat structs,
// state machine type. Used by every file under hw/rtl.
package rptb_pkg;

    localparam int MAX_VERTICES   = 64;
    localparam int MAX_OBJECTIVES = 4;
    localparam int COST_BITS      = 16;
    localparam int VBITS          = $clog2(MAX_VERTICES);
    localparam int OBITS          = 2;
    localparam int DIST_BITS      = 34;
    localparam int SADDR_BITS     = OBITS + 2 * VBITS;
    localparam logic [DIST_BITS-1:0] DIST_UNREACH = '1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;

    localparam logic [2:0] REG_VCOUNT = 3'd0;
    localparam logic [2:0] REG_OCOUNT = 3'd1;
    localparam logic [2:0] REG_W0     = 3'd2;
    localparam logic [2:0] REG_W1     = 3'd3;
    localparam logic [2:0] REG_W2     = 3'd4;
    localparam logic [2:0] REG_W3     = 3'd5;
    localparam logic [2:0] REG_ELIMIT = 3'd6;
    localparam logic [2:0] REG_ACCEPT = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  objective;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] cost_value;
        logic [5:0]  start_vertex;
        logic [15:0] rand_value;
    } t_in_beat;

    typedef struct packed {
        logic [5:0] edge_low;
        logic [5:0] edge_high;
        logic [5:0] edge_index;
        logic       last;
        logic       status;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RELAX,
        ST_RELAX_WB,
        ST_SCAN1,
        ST_THRESH,
        ST_SCAN2,
        ST_PICK,
        ST_SCAN3,
        ST_PARENT,
        ST_EMIT
    } t_state;

endpackage

>>> hw/rtl/rptb_cfg_regs.sv
// APB-style configuration registers for the randomized Prim tree builder.
// Depends on rptb_pkg for register indexes.
module rptb_cfg_regs
    import rptb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [6:0]  o_vertex_count,
    output logic [2:0]  o_objective_count,
    output logic [63:0] o_weights,
    output logic [5:0]  o_edge_limit,
    output logic [15:0] o_accept_fraction
);
    logic [6:0]  r_vc;
    logic [2:0]  r_oc;
    logic [15:0] r_w [4];
    logic [5:0]  r_el;
    logic [15:0] r_af;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc   <= 7'd64;
            r_oc   <= 3'd2;
            r_w[0] <= 16'd32768;
            r_w[1] <= 16'd32768;
            r_w[2] <= 16'd0;
            r_w[3] <= 16'd0;
            r_el   <= 6'd63;
            r_af   <= 16'd1966;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_VCOUNT: r_vc   <= pwdata[6:0];
                REG_OCOUNT: r_oc   <= pwdata[2:0];
                REG_W0:     r_w[0] <= pwdata[15:0];
                REG_W1:     r_w[1] <= pwdata[15:0];
                REG_W2:     r_w[2] <= pwdata[15:0];
                REG_W3:     r_w[3] <= pwdata[15:0];
                REG_ELIMIT: r_el   <= pwdata[5:0];
                REG_ACCEPT: r_af   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_VCOUNT: prdata = {25'd0, r_vc};
            REG_OCOUNT: prdata = {29'd0, r_oc};
            REG_W0:     prdata = {16'd0, r_w[0]};
            REG_W1:     prdata = {16'd0, r_w[1]};
            REG_W2:     prdata = {16'd0, r_w[2]};
            REG_W3:     prdata = {16'd0, r_w[3]};
            REG_ELIMIT: prdata = {26'd0, r_el};
            REG_ACCEPT: prdata = {16'd0, r_af};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_vertex_count    = r_vc;
    assign o_objective_count = r_oc;
    assign o_weights         = {r_w[3], r_w[2], r_w[1], r_w[0]};
    assign o_edge_limit      = r_el;
    assign o_accept_fraction = r_af;
endmodule

>>> hw/rtl/randomized_prim_tree_builder_core.sv
// Randomized Prim tree builder, top level: cost memory, vertex memory and
// the step sequencer. Depends on rptb_pkg and rptb_cfg_regs.
//
// Usage: load beats write one cost each. A start beat clears the vertex
// memory in a pass over all MAX_VERTICES entries (64). An add beat relaxes
// vertex by vertex. Each vertex issues its cost reads, one objective per
// cycle, then drains the read, multiply and accumulate pipeline and ends
// in a write-back state. Three scans of the vertex memory follow, one
// vertex per cycle, the last one stopping once the pick is found, with the
// threshold and pick states between them and the parent and emit states
// after; the later two scans are skipped when the first finds no candidate.
// Each memory has a single read port. The cost memory is cleared by a pass
// over all 16384 entries after reset, during which no beat is taken;
// configuration writes are taken as always. A result beat waits in an
// output register; the next input beat is taken only while that register
// is empty or being drained.
module randomized_prim_tree_builder_core
    import rptb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SDEPTH = MAX_OBJECTIVES * MAX_VERTICES * MAX_VERTICES;
    localparam int VENT   = 1 + DIST_BITS + VBITS;

    logic [6:0]  c_vc;
    logic [2:0]  c_oc;
    logic [63:0] c_w;
    logic [5:0]  c_el;
    logic [15:0] c_af;

    rptb_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_vertex_count(c_vc), .o_objective_count(c_oc), .o_weights(c_w),
        .o_edge_limit(c_el), .o_accept_fraction(c_af)
    );

    // used counts
    logic [VBITS:0] w_nv;
    logic [2:0]     w_nk;
    assign w_nv = (c_vc > 7'(MAX_VERTICES)) ? (VBITS+1)'(MAX_VERTICES) : (VBITS+1)'(c_vc);
    assign w_nk = (c_oc > 3'(MAX_OBJECTIVES)) ? 3'(MAX_OBJECTIVES) : c_oc;

    // cost memory
    logic [COST_BITS-1:0]  m_cost [SDEPTH];
    logic                  w_cwe;
    logic [SADDR_BITS-1:0] w_cwa, w_cra;
    logic [COST_BITS-1:0]  w_cwd, r_crd;
    always_ff @(posedge i_clk) begin
        if (w_cwe) m_cost[w_cwa] <= w_cwd;
        r_crd <= m_cost[w_cra];
    end

    // vertex memory: {in_tree, dist, parent}
    logic [VENT-1:0]  m_vert [MAX_VERTICES];
    logic             w_vwe;
    logic [VBITS-1:0] w_vwa, w_vra;
    logic [VENT-1:0]  w_vwd, r_vrd;
    always_ff @(posedge i_clk) begin
        if (w_vwe) m_vert[w_vwa] <= w_vwd;
        r_vrd <= m_vert[w_vra];
    end
    logic                 v_tree;
    logic [DIST_BITS-1:0] v_dist;
    logic [VBITS-1:0]     v_par;
    assign {v_tree, v_dist, v_par} = r_vrd;

    t_state r_st, n_st;
    logic [SADDR_BITS:0]  r_clr;
    logic                 r_clr_busy;
    logic [VBITS:0]       r_i;      // vertex counter
    logic [2:0]           r_j;      // objective counter
    logic [1:0]           r_jd;     // objective of the word in r_crd
    logic                 r_pv;     // r_crd valid
    logic                 r_rd;     // r_vrd valid for scan
    logic [VBITS-1:0]     r_ri;     // vertex of r_vrd
    logic [DIST_BITS-1:0] r_p;
    logic [31:0]          r_prod;
    logic                 r_prv;
    logic [VBITS-1:0]     r_last;
    logic [5:0]           r_built;
    logic                 r_run;
    logic [DIST_BITS-1:0] r_lo, r_hi, r_thr;
    logic [49:0]          r_span;
    logic [VBITS:0]       r_cnt, r_seen, r_pick;
    logic [VBITS-1:0]     r_chosen;
    logic                 r_found;
    logic [VBITS-1:0]     r_sv;
    logic [15:0]          r_rand;
    logic                 r_ov;
    t_out_beat            r_od;

    logic acc_in, acc_out;
    assign acc_in  = i_in_valid && o_in_ready;
    assign acc_out = r_ov && i_out_ready;
    assign o_in_ready  = (r_st == ST_IDLE) && !r_clr_busy && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    logic w_cand;
    assign w_cand = r_rd && !v_tree && (v_dist != DIST_UNREACH);

    logic [15:0] w_wsel;
    assign w_wsel = c_w[16*r_jd +: 16];

    logic w_relax_done;
    assign w_relax_done = (r_j == w_nk);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                if (acc_in && i_in_data.op == OP_START && 7'(i_in_data.start_vertex) < 7'(w_nv))
                    n_st = ST_CLEAR;
                else if (acc_in && i_in_data.op == OP_ADD && r_run && r_built < c_el)
                    n_st = (w_nv == '0) ? ST_SCAN1 : ST_RELAX;
            end
            ST_CLEAR:    if (r_i == (VBITS+1)'(MAX_VERTICES - 1)) n_st = ST_IDLE;
            ST_RELAX:    if (w_relax_done && !r_pv && !r_prv) n_st = ST_RELAX_WB;
            ST_RELAX_WB: n_st = (r_i + 1'b1 == w_nv) ? ST_SCAN1 : ST_RELAX;
            ST_SCAN1:    if (r_i == w_nv && !r_rd) n_st = (r_cnt == '0) ? ST_EMIT : ST_THRESH;
            ST_THRESH:   n_st = ST_SCAN2;
            ST_SCAN2:    if (r_i == w_nv && !r_rd) n_st = ST_PICK;
            ST_PICK:     n_st = ST_SCAN3;
            ST_SCAN3:    if (r_found || (r_i == w_nv && !r_rd)) n_st = ST_PARENT;
            ST_PARENT:   n_st = ST_EMIT;
            ST_EMIT:     if (!r_ov || i_out_ready) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        w_cwe = 1'b0;
        w_cwa = {i_in_data.objective, i_in_data.row, i_in_data.col};
        w_cwd = i_in_data.cost_value[COST_BITS-1:0];
        w_cra = {r_j[1:0], r_last, r_i[VBITS-1:0]};
        w_vwe = 1'b0;
        w_vwa = r_i[VBITS-1:0];
        w_vwd = {1'b0, DIST_UNREACH, {VBITS{1'b0}}};
        w_vra = r_i[VBITS-1:0];
        if (r_clr_busy) begin
            w_cwe = 1'b1;
            w_cwa = r_clr[SADDR_BITS-1:0];
            w_cwd = '0;
        end else if (acc_in && i_in_data.op == OP_LOAD) begin
            w_cwe = 1'b1;
        end
        unique case (r_st)
            ST_IDLE: begin
                if (acc_in && i_in_data.op == OP_ADD && r_run && r_built < c_el)
                    w_vra = r_last;
            end
            ST_CLEAR: begin
                w_vwe = 1'b1;
                if (r_i[VBITS-1:0] == r_sv) w_vwd = {1'b0, {DIST_BITS{1'b0}}, {VBITS{1'b0}}};
            end
            ST_RELAX: w_vra = r_i[VBITS-1:0];
            ST_RELAX_WB: begin
                // r_vrd holds vertex r_i, read in the relax state
                w_vwe = 1'b1;
                if (r_i[VBITS-1:0] == r_last)
                    w_vwd = {1'b1, v_dist, v_par};
                else if (!v_tree && v_dist > r_p)
                    w_vwd = {1'b0, r_p, r_last};
                else
                    w_vwd = r_vrd;
                w_vra = VBITS'(r_i + 1'b1);
            end
            ST_SCAN1: begin
                // mark the pending vertex when it lies beyond the vertices in use
                if (r_i == '0 && 7'(r_last) >= w_nv) begin
                    w_vwe = 1'b1;
                    w_vwa = r_last;
                    w_vwd = {1'b1, DIST_UNREACH, {VBITS{1'b0}}};
                end
            end
            ST_PARENT: w_vra = r_chosen;
            ST_EMIT:   w_vra = r_chosen;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_clr <= '0;
            r_clr_busy <= 1'b1;
            r_run <= 1'b0;
            r_ov <= 1'b0;
            r_last <= '0;
            r_built <= '0;
            r_pv <= 1'b0;
            r_prv <= 1'b0;
            r_rd <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (SADDR_BITS+1)'(SDEPTH - 1)) r_clr_busy <= 1'b0;
            end
            if (acc_out) r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_prv <= 1'b0;
            r_rd <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_p <= '0;
                    r_cnt <= '0;
                    r_lo <= DIST_UNREACH;
                    r_hi <= '0;
                    r_rand <= i_in_data.rand_value;
                    if (acc_in && i_in_data.op == OP_START &&
                        7'(i_in_data.start_vertex) < 7'(w_nv)) begin
                        r_sv <= i_in_data.start_vertex[VBITS-1:0];
                        r_last <= i_in_data.start_vertex[VBITS-1:0];
                        r_built <= '0;
                        r_run <= 1'b1;
                    end else if (acc_in && i_in_data.op == OP_ADD) begin
                        if (!(r_run && r_built < c_el)) begin
                            r_run <= 1'b0;
                            r_ov <= 1'b1;
                            r_od <= '{default: '0, status: 1'b1};
                        end
                    end
                end
                ST_CLEAR: r_i <= r_i + 1'b1;
                ST_RELAX: begin
                    // issue reads, multiply, accumulate
                    if (!w_relax_done) begin
                        r_j <= r_j + 1'b1;
                        r_pv <= 1'b1;
                        r_jd <= r_j[1:0];
                    end
                    if (r_pv) begin
                        r_prod <= w_wsel * 16'(r_crd);
                        r_prv <= 1'b1;
                    end
                    if (r_prv) r_p <= r_p + DIST_BITS'(r_prod);
                end
                ST_RELAX_WB: begin
                    r_i <= r_i + 1'b1;
                    r_j <= '0;
                    r_p <= '0;
                    if (r_i + 1'b1 == w_nv) begin
                        r_i <= '0;
                        r_cnt <= '0;
                        r_lo <= DIST_UNREACH;
                        r_hi <= '0;
                    end
                end
                ST_SCAN1, ST_SCAN2, ST_SCAN3: begin
                    if (r_i != w_nv) begin
                        r_rd <= 1'b1;
                        r_ri <= r_i[VBITS-1:0];
                        r_i <= r_i + 1'b1;
                    end
                    if (r_st == ST_SCAN1 && w_cand) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (v_dist < r_lo) r_lo <= v_dist;
                        if (v_dist > r_hi) r_hi <= v_dist;
                    end
                    if (r_st == ST_SCAN2 && w_cand && v_dist <= r_thr)
                        r_cnt <= r_cnt + 1'b1;
                    if (r_st == ST_SCAN3 && w_cand && v_dist <= r_thr && !r_found) begin
                        if (r_seen == r_pick) begin
                            r_found <= 1'b1;
                            r_chosen <= r_ri;
                        end
                        r_seen <= r_seen + 1'b1;
                    end
                    if (n_st != r_st) r_i <= '0;
                    if (r_st == ST_SCAN1 && n_st == ST_EMIT) r_run <= 1'b0;
                end
                ST_THRESH: begin
                    r_span <= (r_hi - r_lo) * 50'(c_af) ;
                    r_cnt <= '0;
                    r_i <= '0;
                end
                ST_PICK: begin
                    r_pick <= (VBITS+1)'((32'(r_rand) * 32'(r_cnt)) >> 16);
                    r_seen <= '0;
                    r_found <= 1'b0;
                    r_chosen <= '0;
                end
                ST_EMIT: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov <= 1'b1;
                        if (r_cnt == '0) begin
                            r_od <= '{default: '0, status: 1'b1};
                        end else begin
                            r_od.edge_low   <= 6'((v_par < r_chosen) ? v_par : r_chosen);
                            r_od.edge_high  <= 6'((v_par < r_chosen) ? r_chosen : v_par);
                            r_od.edge_index <= r_built;
                            r_od.last       <= (r_built + 1'b1 == c_el);
                            r_od.status     <= 1'b0;
                            r_built <= r_built + 1'b1;
                            r_last <= r_chosen;
                            if (r_built + 1'b1 == c_el) r_run <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // threshold is registered from the span when scan 2 starts
    always_ff @(posedge i_clk) begin
        if (r_st == ST_SCAN2 && r_i == '0) r_thr <= r_lo + DIST_BITS'(r_span >> 16);
    end

    // r_thr is first used in the cycle after scan 2 starts; data arrives then too
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_st == ST_IDLE && !r_clr_busy)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> (r_ov && $stable(r_od))) else $error("result lost");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od.status) |-> (r_od.edge_low == '0 && r_od.last == 1'b0))
        else $error("failed beat not cleared");
endmodule
